FILE: sv/ple_pkg.sv
// Shared constants, codes and types of the positional list engine.
package ple_pkg;

    localparam int DEPTH = 16;

    // Index of one slot, and a counter that can hold DEPTH itself.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths fixed by the request and result formats.
    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int OCNT_W = 5;

    // Width wide enough to compare position against count without overflow.
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic [IDX_W-1:0]        slot;
        logic signed [VAL_W-1:0] val;
        logic [CNT_W-1:0]        cnt;
    } t_cell_ctrl;

endpackage

FILE: sv/ple_if.sv
// Request and result channel interfaces of the positional list engine.
interface ple_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [ple_pkg::OP_W-1:0]                operation;
    logic signed [ple_pkg::VAL_W-1:0]        value;
    logic [ple_pkg::POS_W-1:0]               position;

    modport source (output valid, operation, value, position, input ready);
    modport sink   (input valid, operation, value, position, output ready);
endinterface

interface ple_out_if;
    logic                       valid;
    logic                       ready;
    logic [ple_pkg::STAT_W-1:0] status;
    logic                       found;
    logic [ple_pkg::OCNT_W-1:0] count;

    modport source (output valid, status, found, count, input ready);
    modport sink   (input valid, status, found, count, output ready);
endinterface

FILE: sv/ple_cell.sv
// One list slot: holds an entry, shifts with its neighbors and matches searches.
module ple_cell (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [ple_pkg::IDX_W-1:0]        i_idx,
    input  ple_pkg::t_cell_ctrl              i_ctrl,
    input  logic signed [ple_pkg::VAL_W-1:0] i_left,
    input  logic signed [ple_pkg::VAL_W-1:0] i_right,
    output logic signed [ple_pkg::VAL_W-1:0] o_entry,
    output logic                             o_hit
);

    logic signed [ple_pkg::VAL_W-1:0] r_entry;
    logic signed [ple_pkg::VAL_W-1:0] n_entry;
    logic                             w_at;
    logic                             w_after;

    assign w_at    = (i_idx == i_ctrl.slot);
    assign w_after = (i_idx > i_ctrl.slot);

    // Insert pulls from the left neighbor past the slot; delete pulls from the right.
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (w_at) begin
                n_entry = i_ctrl.val;
            end else if (w_after) begin
                n_entry = i_left;
            end
        end else if (i_ctrl.del) begin
            if (w_at || w_after) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = (ple_pkg::CNT_W'(i_idx) < i_ctrl.cnt) && (r_entry == i_ctrl.val);

endmodule

FILE: sv/positional_list_engine_core.sv
// Top level of the positional list engine: request decode, cell chain and result register.
//
//   channel  | dir | handshake     | payload
//   i_in     | in  | valid / ready | operation, value, position
//   o_out    | out | valid / ready | status, found, count
//
// The cells shift or compare in parallel for each request and its result is registered, so
// one request is taken per cycle while results drain.
// A new request is accepted whenever the result register is empty or being taken.
// Reset clears the count and the result valid; stored entries are left as they are.
// No clearing pass follows reset, so requests are accepted on the first cycle after it.
module positional_list_engine_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ple_in_if.sink        i_in,
    ple_out_if.source     o_out
);

    logic [ple_pkg::CNT_W-1:0]  r_len;
    logic [ple_pkg::CNT_W-1:0]  n_len;
    logic                       r_out_valid;
    logic [ple_pkg::STAT_W-1:0] r_status;
    logic [ple_pkg::STAT_W-1:0] n_status;
    logic                       r_found;
    logic                       n_found;
    logic [ple_pkg::OCNT_W-1:0] r_count;

    logic                       w_accept;
    logic [ple_pkg::CMP_W-1:0]  w_pos;
    logic [ple_pkg::CMP_W-1:0]  w_len;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_ins_ok;
    logic                       w_del_ok;
    logic                       w_any_hit;
    logic [ple_pkg::CMP_W-1:0]  w_len_ext;
    ple_pkg::t_cell_ctrl        w_ctrl;

    logic signed [ple_pkg::VAL_W-1:0] w_entry [ple_pkg::DEPTH];
    logic [ple_pkg::DEPTH-1:0]        w_hit;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_pos   = ple_pkg::CMP_W'(i_in.position);
    assign w_len   = ple_pkg::CMP_W'(r_len);
    assign w_full  = (w_len >= ple_pkg::CMP_W'(ple_pkg::DEPTH));
    assign w_empty = (r_len == '0);

    assign w_ins_ok = (i_in.operation == ple_pkg::OP_INSERT) && !w_full
                      && (w_pos != '0) && (w_pos <= w_len + ple_pkg::CMP_W'(1));
    assign w_del_ok = (i_in.operation == ple_pkg::OP_DELETE) && !w_empty
                      && (w_pos != '0) && (w_pos <= w_len);

    always_comb begin
        w_ctrl.ins  = w_ins_ok;
        w_ctrl.del  = w_del_ok;
        w_ctrl.slot = ple_pkg::IDX_W'(w_pos - ple_pkg::CMP_W'(1));
        w_ctrl.val  = i_in.value;
        w_ctrl.cnt  = r_len;
    end

    genvar k;
    generate
        for (k = 0; k < ple_pkg::DEPTH; k++) begin : g_cell
            logic signed [ple_pkg::VAL_W-1:0] w_left;
            logic signed [ple_pkg::VAL_W-1:0] w_right;

            if (k == 0) begin : g_first
                assign w_left = i_in.value;
            end else begin : g_mid_l
                assign w_left = w_entry[k-1];
            end

            if (k == ple_pkg::DEPTH - 1) begin : g_last
                assign w_right = w_entry[k];
            end else begin : g_mid_r
                assign w_right = w_entry[k+1];
            end

            ple_cell u_cell (
                .i_clk   (i_clk),
                .i_en    (w_accept),
                .i_idx   (ple_pkg::IDX_W'(k)),
                .i_ctrl  (w_ctrl),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_entry[k]),
                .o_hit   (w_hit[k])
            );
        end
    endgenerate

    assign w_any_hit = |w_hit;

    always_comb begin
        n_len    = r_len;
        n_status = ple_pkg::ST_OK;
        n_found  = 1'b0;
        unique case (i_in.operation)
            ple_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = ple_pkg::ST_FULL;
                end else if (!w_ins_ok) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    n_len = r_len + ple_pkg::CNT_W'(1);
                end
            end
            ple_pkg::OP_DELETE: begin
                if (w_empty) begin
                    n_status = ple_pkg::ST_EMPTY;
                end else if (!w_del_ok) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    n_len = r_len - ple_pkg::CNT_W'(1);
                end
            end
            ple_pkg::OP_SEARCH: begin
                if (w_empty) begin
                    n_status = ple_pkg::ST_EMPTY;
                end else begin
                    n_found = w_any_hit;
                end
            end
            default: begin
                n_status = ple_pkg::ST_OK;
            end
        endcase
    end

    assign w_len_ext = ple_pkg::CMP_W'(n_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_count  <= w_len_ext[ple_pkg::OCNT_W-1:0];
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_status;
    assign o_out.found  = r_found;
    assign o_out.count  = r_count;

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ple_pkg::CMP_W'(r_len) <= ple_pkg::CMP_W'(ple_pkg::DEPTH))
        else $error("list length exceeds depth");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ins_ok) |=> (r_len == $past(r_len) + ple_pkg::CNT_W'(1)))
        else $error("accepted insert did not grow the list");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ple_pkg::ST_FULL)
        |-> (ple_pkg::CMP_W'(r_len) == ple_pkg::CMP_W'(ple_pkg::DEPTH)))
        else $error("full status reported while list not full");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found) |-> (r_status == ple_pkg::ST_OK))
        else $error("found flag set on a rejected request");
`endif

endmodule

FILE: test/tb_positional_list_engine_core.sv
// Self-checking testbench of the positional list engine: directed and random requests, scoreboard.
module tb_positional_list_engine_core;
    import ple_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [VAL_W-1:0]  value;
        logic [POS_W-1:0]         pos;
        bit                       drain_first;
        int                       phase;
    } list_req_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [OCNT_W-1:0] count;
    } list_result_t;

    logic i_clk;
    logic i_rst_n;

    ple_in_if  req_ch ();
    ple_out_if res_ch ();

    positional_list_engine_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    // Mirror of the stored list, updated as each request transfer is seen.
    logic signed [VAL_W-1:0] list_vals [DEPTH];
    int                      list_len;

    list_req_t    pending [$];
    list_result_t results_due [$];

    int send_idle [3] = '{23, 45, 0};
    int recv_idle [3] = '{45, 23, 0};
    int cur_phase;
    int mismatches;
    int accepted;
    int n_checked, n_hits, n_full, n_range, n_empty;

    // Stimulus generation state: length of the list as the generator sees it.
    int                      gen_len;
    logic signed [VAL_W-1:0] value_pool [$];

    always #6 i_clk = ~i_clk;

    function automatic list_result_t apply_request(list_req_t r);
        list_result_t res;
        int           k;
        int           p;
        res = '{ST_OK, 1'b0, '0};
        p   = int'(r.pos);
        case (r.op)
            OP_INSERT: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (p == 0 || p > list_len + 1) begin
                    res.status = ST_RANGE;
                end else begin
                    for (k = list_len; k >= p; k--) list_vals[k] = list_vals[k-1];
                    list_vals[p-1] = r.value;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p == 0 || p > list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (k = p - 1; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
                    list_len--;
                end
            end
            OP_SEARCH: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (k = 0; k < list_len; k++) begin
                        if (list_vals[k] === r.value) res.found = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.count = OCNT_W'(list_len);
        return res;
    endfunction

    task automatic queue_req(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value,
                             logic [POS_W-1:0] pos, bit drain_first, int phase);
        int p;
        p = int'(pos);
        pending.push_back('{op, value, pos, drain_first, phase});
        if (op == OP_INSERT && gen_len < DEPTH && p >= 1 && p <= gen_len + 1) begin
            gen_len++;
            value_pool.push_back(value);
            if (value_pool.size() > 12) void'(value_pool.pop_front());
        end else if (op == OP_DELETE && gen_len > 0 && p >= 1 && p <= gen_len) begin
            gen_len--;
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45 && value_pool.size() != 0) return value_pool[$urandom_range(value_pool.size() - 1)];
        if (r < 60) begin
            case ($urandom_range(4))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return -32'sd1;
                3: return 32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: a new request goes out once the previous one has been transferred.
    always @(posedge i_clk) begin
        list_req_t on_bus;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) begin
                results_due.push_back(apply_request(on_bus));
                accepted++;
            end
            if (pending.size() != 0 && !(pending[0].drain_first && results_due.size() != 0)
                && $urandom_range(99) >= send_idle[pending[0].phase]) begin
                on_bus = pending.pop_front();
                cur_phase = on_bus.phase;
                req_ch.valid     <= 1'b1;
                req_ch.operation <= on_bus.op;
                req_ch.value     <= on_bus.value;
                req_ch.position  <= on_bus.pos;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: each result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        list_result_t want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (results_due.size() == 0) begin
                    $error("result with no request outstanding: status %0d found %0d count %0d",
                           res_ch.status, res_ch.found, res_ch.count);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", want.status, res_ch.status);
                    check_field("found", want.found, res_ch.found);
                    check_field("count", want.count, res_ch.count);
                    n_checked++;
                    if (want.found) n_hits++;
                    if (want.status == ST_FULL) n_full++;
                    if (want.status == ST_RANGE) n_range++;
                    if (want.status == ST_EMPTY) n_empty++;
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle[cur_phase]);
        end
    end

    // Watchdog: too long without any transfer means the block is stuck.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n, bias, r, ins_pct, del_pct, phase;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        bit               drain;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_NONE;
        req_ch.value = '0;
        req_ch.position = '0;
        res_ch.ready = 1'b0;
        list_len = 0;
        gen_len = 0;
        cur_phase = 0;
        mismatches = 0;
        accepted = 0;
        n_checked = 0; n_hits = 0; n_full = 0; n_range = 0; n_empty = 0;

        // Directed part: empty-list handling, position limits, extreme values, unused code.
        queue_req(OP_SEARCH, 32'sd0, 5'd1, 1'b0, 0);
        queue_req(OP_DELETE, 32'sd0, 5'd1, 1'b0, 0);
        queue_req(OP_INSERT, 32'sd5, 5'd0, 1'b0, 0);
        queue_req(OP_INSERT, 32'sd5, 5'd2, 1'b0, 0);
        queue_req(OP_INSERT, 32'sh7FFFFFFF, 5'd1, 1'b0, 0);
        queue_req(OP_INSERT, 32'sh80000000, 5'd1, 1'b0, 0);
        queue_req(OP_INSERT, 32'sd0, 5'd3, 1'b0, 0);
        queue_req(OP_INSERT, -32'sd1, 5'd2, 1'b0, 0);
        queue_req(OP_SEARCH, 32'sh80000000, 5'd0, 1'b0, 0);
        queue_req(OP_SEARCH, 32'sh7FFFFFFF, 5'd31, 1'b0, 0);
        queue_req(OP_SEARCH, 32'sd1, 5'd1, 1'b0, 0);
        queue_req(OP_NONE, -32'sd1, 5'd31, 1'b0, 0);
        queue_req(OP_INSERT, 32'sd9, 5'd31, 1'b0, 0);
        queue_req(OP_DELETE, 32'sd0, 5'd0, 1'b0, 0);
        queue_req(OP_DELETE, 32'sd0, 5'd5, 1'b0, 0);
        queue_req(OP_DELETE, 32'sd0, 5'd4, 1'b0, 0);
        queue_req(OP_DELETE, 32'sd0, 5'd1, 1'b0, 0);
        queue_req(OP_SEARCH, 32'sh80000000, 5'd1, 1'b0, 0);
        queue_req(OP_DELETE, 32'sd0, 5'd1, 1'b0, 0);
        queue_req(OP_DELETE, 32'sd0, 5'd1, 1'b0, 0);
        queue_req(OP_SEARCH, -32'sd1, 5'd1, 1'b0, 0);
        queue_req(OP_NONE, 32'sd0, 5'd0, 1'b0, 0);

        // Random part: blocks that grow, shrink or hold the list so it swings between
        // empty and full; most positions are legal for the current length.
        n = 0;
        bias = 0;
        while (n < RANDOM_ITEMS) begin
            phase = n * 3 / RANDOM_ITEMS;
            drain = (n % 317 == 0) || (n == RANDOM_ITEMS / 3) || (n == 2 * RANDOM_ITEMS / 3);
            if (n % 120 == 0) bias = (n == 0) ? 0 : $urandom_range(2);
            ins_pct = (bias == 0) ? 60 : (bias == 1) ? 20 : 38;
            del_pct = (bias == 0) ? 15 : (bias == 1) ? 55 : 32;
            r = $urandom_range(99);
            if (r < ins_pct) op = OP_INSERT;
            else if (r < ins_pct + del_pct) op = OP_DELETE;
            else if (r < 96) op = OP_SEARCH;
            else op = OP_NONE;
            if ($urandom_range(99) < 85 && op == OP_INSERT && gen_len < DEPTH)
                pos = POS_W'($urandom_range(gen_len + 1, 1));
            else if ($urandom_range(99) < 85 && op == OP_DELETE && gen_len > 0)
                pos = POS_W'($urandom_range(gen_len, 1));
            else
                pos = POS_W'($urandom_range(31, 0));
            queue_req(op, pick_value(), pos, drain, phase);
            if (op != OP_NONE) n++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || req_ch.valid || results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests through insert, delete and search; %0d results checked.",
                 accepted, n_checked);
        $display("Search hits %0d, full rejects %0d, position rejects %0d, empty-list %0d.",
                 n_hits, n_full, n_range, n_empty);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: positional_list_engine_core.f
sv/ple_pkg.sv
sv/ple_if.sv
sv/ple_cell.sv
sv/positional_list_engine_core.sv
test/tb_positional_list_engine_core.sv
